>>> design/eight_bit_register_alu_defines.svh
// Assertion macros used by the register ALU top level.
`ifndef EIGHT_BIT_REGISTER_ALU_DEFINES_SVH
`define EIGHT_BIT_REGISTER_ALU_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check that is masked while reset is high.
`define EBRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define EBRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EBRA_ASSERT(label, clk, rst, prop, msg)
`define EBRA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> design/ebra_pkg.sv
// Package with widths, operation codes and sequencer states of the register ALU.
`default_nettype none

package ebra_pkg;

   // Field widths of the request and response transactions.
   localparam int OP_W    = 4;
   localparam int IDX_W   = 4;
   localparam int DATA_W  = 8;

   // The divider retires one quotient bit per cycle.
   localparam int DIV_STEPS = DATA_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Operation codes carried in the req_type field.
   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_UDIV  = 4'd3,
      OP_INC   = 4'd4,
      OP_DEC   = 4'd5,
      OP_SADD  = 4'd6,
      OP_SSUB  = 4'd7,
      OP_SMUL  = 4'd8,
      OP_SDIV  = 4'd9,
      OP_WRITE = 4'd10
   } op_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

>>> design/ebra_req_if.sv
// Request channel interface: operation, register indices and write byte.
`default_nettype none

interface ebra_req_if;
   import ebra_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [IDX_W-1:0]  first_reg;
   logic [IDX_W-1:0]  second_reg;
   logic [DATA_W-1:0] write_value;

   modport source (
      output valid, req_type, first_reg, second_reg, write_value,
      input  ready
   );

   modport sink (
      input  valid, req_type, first_reg, second_reg, write_value,
      output ready
   );
endinterface

`default_nettype wire

>>> design/ebra_rsp_if.sv
// Response channel interface: accumulator and target register value.
`default_nettype none

interface ebra_rsp_if;
   import ebra_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] accumulator;
   logic [DATA_W-1:0] target_value;

   modport source (
      output valid, accumulator, target_value,
      input  ready
   );

   modport sink (
      input  valid, accumulator, target_value,
      output ready
   );
endinterface

`default_nettype wire

>>> design/eight_bit_register_alu.sv
// Top level of the 8-bit ALU with register file and accumulator.
//
//  channel   direction  handshake         payload
//  req_bus   in         valid / ready     req_type, first_reg, second_reg, write_value
//  rsp_bus   out        valid / ready     accumulator, target_value
//
// A transaction passes from acceptance to a loaded response through accept,
// register file read and execute, with the divider states in between for udiv
// and sdiv, whose divider retires one quotient bit per cycle. A new request is
// taken in the cycle after execute.
// Reset clears the accumulator and the per-register valid bits, so every register
// reads as zero until written; there is no clearing pass.
// The response register frees the input side; execute waits only while a
// response is still held and not yet taken.
`default_nettype none
`include "eight_bit_register_alu_defines.svh"

module eight_bit_register_alu #(
   parameter int NUM_REGS = 16
) (
   input wire logic clock,
   input wire logic reset,
   ebra_req_if.sink   req_bus,
   ebra_rsp_if.source rsp_bus
);
   import ebra_pkg::*;

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   // Index compare width: wide enough for the index, the address and NUM_REGS.
   localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;

   // Sequencer state and captured request.
   state_type         state_ff, state_in;
   op_type            op_ff;
   logic [AW-1:0]     ia_addr_ff;
   logic              ia_ok_ff, ib_ok_ff;
   logic              va_ff, vb_ff;
   logic [DATA_W-1:0] wv_ff;

   // Operands, divider and architectural accumulator.
   logic [DATA_W-1:0] a_ff, b_ff;
   logic [DATA_W-1:0] quo_ff, rem_ff, dvs_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [NUM_REGS-1:0] valid_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_acc_ff, rsp_tgt_ff;

   // Control outputs of the sequencer.
   logic req_ready;
   logic commit;
   logic rf_we;

   // Address decode of the incoming request.
   logic [XW-1:0] ia_ext, ib_ext;
   logic          ia_ok, ib_ok;
   logic [AW-1:0] ia_addr, ib_addr;

   assign ia_ext  = XW'(req_bus.first_reg);
   assign ib_ext  = XW'(req_bus.second_reg);
   assign ia_ok   = ia_ext < XW'(NUM_REGS);
   assign ib_ok   = ib_ext < XW'(NUM_REGS);
   assign ia_addr = ia_ext[AW-1:0];
   assign ib_addr = ib_ext[AW-1:0];

   // Register file: two copies written together give two read ports.
   logic [DATA_W-1:0] rd_a, rd_b, rf_wdata;

   ebra_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
      .clock (clock),
      .we    (rf_we),
      .waddr (ia_addr_ff),
      .wdata (rf_wdata),
      .raddr (ia_addr),
      .rdata (rd_a)
   );

   ebra_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
      .clock (clock),
      .we    (rf_we),
      .waddr (ia_addr_ff),
      .wdata (rf_wdata),
      .raddr (ib_addr),
      .rdata (rd_b)
   );

   // Operands read as zero when out of range or never written.
   logic [DATA_W-1:0] a_val, b_val, ma, mb;
   logic              is_sdiv;

   assign a_val   = (ia_ok_ff && va_ff) ? rd_a : '0;
   assign b_val   = (ib_ok_ff && vb_ff) ? rd_b : '0;
   assign is_sdiv = (op_ff == OP_SDIV);
   assign ma      = (is_sdiv && a_val[DATA_W-1]) ? (~a_val + DATA_W'(1)) : a_val;
   assign mb      = (is_sdiv && b_val[DATA_W-1]) ? (~b_val + DATA_W'(1)) : b_val;

   // One restoring division step on the magnitudes.
   logic [DATA_W:0]   trial, trial_sub;
   logic              trial_ge;
   logic [DATA_W-1:0] rem_in, quo_in;

   assign trial     = {rem_ff, quo_ff[DATA_W-1]};
   assign trial_ge  = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign rem_in    = trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
   assign quo_in    = {quo_ff[DATA_W-2:0], trial_ge};

   // Execute: new accumulator, register write and target value.
   logic [2*DATA_W-1:0] prod;
   logic [DATA_W-1:0]   quot, acc_in, tgt;
   logic                wr_op;

   assign prod = a_ff * b_ff;
   assign quot = (b_ff == '0) ? '0 : (neg_ff ? (~quo_ff + DATA_W'(1)) : quo_ff);

   always_comb begin
      acc_in   = acc_ff;
      rf_wdata = a_ff;
      wr_op    = 1'b0;
      case (op_ff)
         OP_ADD, OP_SADD: acc_in = a_ff + b_ff;
         OP_SUB, OP_SSUB: acc_in = a_ff - b_ff;
         OP_MUL, OP_SMUL: acc_in = prod[DATA_W-1:0];
         OP_UDIV, OP_SDIV: acc_in = quot;
         OP_INC: begin
            rf_wdata = a_ff + DATA_W'(1);
            wr_op    = 1'b1;
         end
         OP_DEC: begin
            rf_wdata = a_ff - DATA_W'(1);
            wr_op    = 1'b1;
         end
         OP_WRITE: begin
            rf_wdata = wv_ff;
            wr_op    = 1'b1;
         end
         default: acc_in = acc_ff;
      endcase
   end

   // An out-of-range target reads as zero and ignores writes.
   assign tgt = wr_op ? (ia_ok_ff ? rf_wdata : '0) : a_ff;

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (op_ff == OP_UDIV || op_ff == OP_SDIV) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: commit    = out_free;
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   assign rf_we = commit && wr_op && ia_ok_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            acc_ff <= acc_in;
         end
         if (rf_we) begin
            valid_ff[ia_addr_ff] <= 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: captured request, operands, divider and response.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_ready) begin
         op_ff      <= op_type'(req_bus.req_type);
         ia_addr_ff <= ia_addr;
         ia_ok_ff   <= ia_ok;
         ib_ok_ff   <= ib_ok;
         va_ff      <= valid_ff[ia_addr];
         vb_ff      <= valid_ff[ib_addr];
         wv_ff      <= req_bus.write_value;
      end
      if (state_ff == ST_READ) begin
         a_ff   <= a_val;
         b_ff   <= b_val;
         quo_ff <= ma;
         dvs_ff <= mb;
         rem_ff <= '0;
         neg_ff <= is_sdiv && (a_val[DATA_W-1] ^ b_val[DATA_W-1]);
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (commit) begin
         rsp_acc_ff <= acc_in;
         rsp_tgt_ff <= tgt;
      end
   end

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.accumulator  = rsp_acc_ff;
   assign rsp_bus.target_value = rsp_tgt_ff;

   // Checks on the sequencer.
   `EBRA_ASSERT(a_accept_reads, clock, reset, (req_bus.valid && req_bus.ready) |=> (state_ff == ST_READ), "accepted request did not start a read")
   `EBRA_ASSERT(a_div_ends, clock, reset, (state_ff == ST_DIV && cnt_ff == CNT_W'(DIV_STEPS - 1)) |=> (state_ff == ST_EXEC), "divider overran its step count")
   `EBRA_ASSERT(a_commit_resp, clock, reset, commit |=> (rsp_bus.valid && state_ff == ST_IDLE), "commit did not load a response")
   `EBRA_ASSERT(a_exec_holds, clock, reset, (state_ff == ST_EXEC && !out_free) |=> (state_ff == ST_EXEC && $stable(acc_ff)), "execute moved on while response was stalled")

endmodule

`default_nettype wire

>>> design/ebra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ebra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
